FILE: rtl/vha_pkg.sv
package vha_pkg;

    localparam int INDEX_BITS   = 10;
    localparam int VERSION_BITS = 6;
    localparam int HANDLE_BITS  = INDEX_BITS + VERSION_BITS;
    localparam int SLOT_DEPTH   = 1 << INDEX_BITS;

    typedef logic [INDEX_BITS-1:0]   index_t;
    typedef logic [INDEX_BITS:0]     count_t;
    typedef logic [VERSION_BITS-1:0] version_t;
    typedef logic [HANDLE_BITS-1:0]  handle_t;
    typedef logic [1:0]              action_t;
    typedef logic [1:0]              status_t;

    localparam count_t   SLOT_COUNT       = count_t'(1) << INDEX_BITS;
    localparam version_t VERSION_ALL_ONES = '1;
    localparam handle_t  NULL_HANDLE      = '1;

    localparam action_t ACT_ALLOC    = 2'd0;
    localparam action_t ACT_FREE     = 2'd1;
    localparam action_t ACT_VALIDATE = 2'd2;

    localparam status_t STAT_OK        = 2'd0;
    localparam status_t STAT_NOT_ALIVE = 2'd1;
    localparam status_t STAT_FULL      = 2'd2;

    typedef struct packed {
        action_t action;
        handle_t handle;
    } req_t;

    typedef struct packed {
        handle_t result_handle;
        logic    alive;
        status_t status;
    } rsp_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    function automatic index_t idx_of(input handle_t h);
        return h[HANDLE_BITS-1:VERSION_BITS];
    endfunction

endpackage

FILE: rtl/vha_ram.sv
module vha_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    parameter int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/versioned_handle_allocator.sv
// On acceptance the request and the slot RAM read are registered; the result is registered
// in ST_EXEC once any waiting result is taken. A new request is taken only in ST_IDLE, after
// the previous one completes: the slot RAM's registered read and the write-back of that entry.
// A waiting result does not block acceptance of the next request.
// Reset (async, active low) clears slots_used, free_count and the output valid,
// and sets the free head to the null handle; the slot RAM is not cleared.
module versioned_handle_allocator (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  vha_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output vha_pkg::rsp_t rsp
);
    import vha_pkg::*;

    state_t  state_reg, state_next;
    req_t    req_q_reg;
    rsp_t    rsp_reg, rsp_next;
    logic    rsp_valid_reg, rsp_valid_next;
    handle_t free_head_reg, free_head_next;
    count_t  free_count_reg, free_count_next;
    count_t  slots_used_reg, slots_used_next;

    logic    rd_en;
    index_t  rd_addr;
    handle_t rd_data;
    logic    wr_req;
    index_t  wr_addr;
    handle_t wr_data;
    logic    complete;

    index_t   exec_idx;
    version_t exec_ver;
    version_t ver_inc;
    logic     handle_live;

    vha_ram #(
        .WIDTH(HANDLE_BITS),
        .DEPTH(SLOT_DEPTH)
    ) u_slot_ram (
        .clk  (clk),
        .we   (wr_req && complete),
        .waddr(wr_addr),
        .wdata(wr_data),
        .re   (rd_en),
        .raddr(rd_addr),
        .rdata(rd_data)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (complete)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        req_ready = 1'b0;
        complete  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
            end
            ST_EXEC:
            begin
                complete = !rsp_valid_reg || rsp_ready;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    // allocation reads the entry under the free head, everything else the handle's slot
    assign rd_en   = req_valid && req_ready;
    assign rd_addr = (req.action == ACT_ALLOC) ? idx_of(free_head_reg) : idx_of(req.handle);

    assign exec_idx    = idx_of(req_q_reg.handle);
    assign exec_ver    = req_q_reg.handle[VERSION_BITS-1:0];
    assign ver_inc     = version_t'(exec_ver + 1'b1);
    assign handle_live = ({1'b0, exec_idx} < slots_used_reg)
                         && (exec_ver != VERSION_ALL_ONES)
                         && (rd_data == req_q_reg.handle);

    always_comb
    begin
        wr_req          = 1'b0;
        wr_addr         = exec_idx;
        wr_data         = free_head_reg;
        free_head_next  = free_head_reg;
        free_count_next = free_count_reg;
        slots_used_next = slots_used_reg;
        rsp_next        = '{result_handle: NULL_HANDLE, alive: 1'b0, status: STAT_OK};
        case (req_q_reg.action)
            ACT_ALLOC:
            begin
                if (free_count_reg != '0)
                begin
                    // pop: the entry holds the link to the next free handle
                    rsp_next.result_handle = free_head_reg;
                    wr_req          = 1'b1;
                    wr_addr         = idx_of(free_head_reg);
                    wr_data         = free_head_reg;
                    free_head_next  = rd_data;
                    free_count_next = count_t'(free_count_reg - 1'b1);
                end
                else if (slots_used_reg < SLOT_COUNT)
                begin
                    rsp_next.result_handle = {slots_used_reg[INDEX_BITS-1:0], version_t'(0)};
                    wr_req          = 1'b1;
                    wr_addr         = slots_used_reg[INDEX_BITS-1:0];
                    wr_data         = {slots_used_reg[INDEX_BITS-1:0], version_t'(0)};
                    slots_used_next = count_t'(slots_used_reg + 1'b1);
                end
                else
                begin
                    rsp_next.status = STAT_FULL;
                end
            end
            ACT_FREE:
            begin
                if (handle_live)
                begin
                    rsp_next.result_handle = req_q_reg.handle;
                    rsp_next.alive         = 1'b1;
                    wr_req                 = 1'b1;
                    wr_addr                = exec_idx;
                    if (ver_inc != VERSION_ALL_ONES)
                    begin
                        wr_data         = free_head_reg;
                        free_head_next  = {exec_idx, ver_inc};
                        free_count_next = count_t'(free_count_reg + 1'b1);
                    end
                    else
                    begin
                        // version exhausted: retire the slot
                        wr_data = {exec_idx, ver_inc};
                    end
                end
                else
                begin
                    rsp_next.status = STAT_NOT_ALIVE;
                end
            end
            default:
            begin
                if (handle_live)
                begin
                    rsp_next.result_handle = req_q_reg.handle;
                    rsp_next.alive         = 1'b1;
                end
                else
                begin
                    rsp_next.status = STAT_NOT_ALIVE;
                end
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (complete)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rsp_valid_reg  <= 1'b0;
            free_head_reg  <= NULL_HANDLE;
            free_count_reg <= '0;
            slots_used_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (complete)
            begin
                free_head_reg  <= free_head_next;
                free_count_reg <= free_count_next;
                slots_used_reg <= slots_used_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            req_q_reg <= req;
        end
        if (complete)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_free_le_used: assert property (@(posedge clk) disable iff (!rst_n)
        free_count_reg <= slots_used_reg)
        else $error("free list longer than the allocated slot range");

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        slots_used_reg <= SLOT_COUNT)
        else $error("slots_used beyond table size");

    a_full_null: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == STAT_FULL) |->
            (rsp.result_handle == NULL_HANDLE && !rsp.alive))
        else $error("full status without null handle");

    a_exec_done: assert property (@(posedge clk) disable iff (!rst_n)
        complete |=> (rsp_valid && state_reg == ST_IDLE))
        else $error("completed transaction did not post a result");

    a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (complete && rsp_next.status == STAT_FULL) |->
            (free_count_reg == '0 && slots_used_reg == SLOT_COUNT))
        else $error("full flagged while slots remain");

endmodule
